// ----- hdl/mccb_pkg.sv -----
// Shared constants, command type and byte-wise CRC step for the CRC channel bank.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package mccb_pkg;

    // Bank geometry.
    localparam int CRC_WIDTH = 32;
    localparam int CHANNELS  = 16;

    // Fixed field widths of the request and result channels.
    localparam int MODE_W = 2;
    localparam int MASK_W = 16;
    localparam int DATA_W = 32;
    localparam int READ_W = 32;

    // Width of a channel index.
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [CRC_WIDTH-1:0] crc_t;

    // Operation codes.
    localparam mode_t MODE_UPDATE    = mode_t'(0);
    localparam mode_t MODE_SET_VALUE = mode_t'(1);
    localparam mode_t MODE_SET_POLY  = mode_t'(2);
    localparam mode_t MODE_READ      = mode_t'(3);

    // A classified request as it waits in the queue.
    typedef struct packed {
        mode_t                 mode;
        logic [CHANNELS-1:0]   chan_mask;
        crc_t                  word;
        logic                  status;
        logic [IDX_W-1:0]      read_idx;
    } cmd_t;

    // One byte, MSB first and unreflected, through eight shift-and-XOR steps.
    function automatic crc_t crc_byte(crc_t crc, crc_t poly, logic [7:0] data);
        crc_t acc;
        acc = crc ^ (crc_t'(data) << (CRC_WIDTH - 8));
        for (int k = 0; k < 8; k++)
        begin
            if (acc[CRC_WIDTH-1])
            begin
                acc = (acc << 1) ^ poly;
            end
            else
            begin
                acc = acc << 1;
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mccb_if.sv -----
// Valid/ready channel interfaces for requests into and results out of the CRC bank.
// Depends on mccb_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mccb_req_if;
    logic                         valid;
    logic                         ready;
    mccb_pkg::mode_t              mode;
    logic [mccb_pkg::MASK_W-1:0]  channel_mask;
    logic [mccb_pkg::DATA_W-1:0]  data_word;

    modport source (output valid, output mode, output channel_mask, output data_word,
                    input ready);
    modport sink   (input valid, input mode, input channel_mask, input data_word,
                    output ready);
endinterface

interface mccb_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [mccb_pkg::READ_W-1:0]  read_value;
    logic                         status;

    modport source (output valid, output read_value, output status, input ready);
    modport sink   (input valid, input read_value, input status, output ready);
endinterface

`default_nettype wire

// ----- hdl/mccb_front.sv -----
// Front end of the CRC bank: decodes a request into a queue command.
// Depends on mccb_pkg and the request interface in mccb_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module mccb_front (
    mccb_req_if.sink         request,
    output logic             push_valid,
    input  logic             push_ready,
    output mccb_pkg::cmd_t   push_cmd
);
    import mccb_pkg::*;

    logic [MASK_W-1:0] mask;
    logic              any_bit;
    logic              one_hot;
    logic              in_range;
    logic [IDX_W-1:0]  read_idx;
    logic              status;

    // The request passes straight to the queue; the queue decides acceptance.
    assign push_valid    = request.valid;
    assign request.ready = push_ready;

    // Mask properties.
    assign mask     = request.channel_mask;
    assign any_bit  = |mask;
    assign one_hot  = any_bit && ((mask & (mask - MASK_W'(1))) == '0);
    assign in_range = |mask[CHANNELS-1:0];

    // Encode the one-hot mask into a channel index.
    always_comb
    begin
        read_idx = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (mask[c])
            begin
                read_idx = read_idx | IDX_W'(c);
            end
        end
    end

    // Status: sets need a nonempty mask, reads need one existing channel.
    always_comb
    begin
        case (request.mode)
            MODE_UPDATE:    status = 1'b0;
            MODE_SET_VALUE: status = !any_bit;
            MODE_SET_POLY:  status = !any_bit;
            MODE_READ:      status = !(one_hot && in_range);
            default:        status = 1'b1;
        endcase
    end

    assign push_cmd.mode      = request.mode;
    assign push_cmd.chan_mask = mask[CHANNELS-1:0];
    assign push_cmd.word      = crc_t'(request.data_word);
    assign push_cmd.status    = status;
    assign push_cmd.read_idx  = read_idx;

endmodule

`default_nettype wire

// ----- hdl/mccb_queue.sv -----
// Short command queue that decouples the CRC bank front end from its back end.
// Depends on mccb_pkg for the command type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module mccb_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  mccb_pkg::cmd_t   push_cmd,
    output logic             pop_valid,
    input  logic             pop_ready,
    output mccb_pkg::cmd_t   pop_cmd
);
    import mccb_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mccb_back.sv -----
// Back end of the CRC bank: channel state, byte update, and the result register.
// Depends on mccb_pkg and the result interface in mccb_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module mccb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  mccb_pkg::cmd_t   pop_cmd,
    mccb_rsp_if.source       result
);
    import mccb_pkg::*;

    crc_t              value_reg  [CHANNELS];
    crc_t              value_next [CHANNELS];
    crc_t              poly_reg   [CHANNELS];
    crc_t              poly_next  [CHANNELS];
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [READ_W-1:0] read_value_reg;
    logic [READ_W-1:0] read_value_next;
    logic              status_reg;
    logic              status_next;
    logic              exec;

    // A command executes whenever the result register is free or being drained.
    assign pop_ready = !out_valid_reg || result.ready;
    assign exec      = pop_valid && pop_ready;

    // Per-channel state update for every masked channel.
    always_comb
    begin
        value_next = value_reg;
        poly_next  = poly_reg;
        if (exec)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (pop_cmd.chan_mask[c])
                begin
                    case (pop_cmd.mode)
                        MODE_UPDATE:
                        begin
                            value_next[c] = crc_byte(value_reg[c], poly_reg[c],
                                                     pop_cmd.word[7:0]);
                        end
                        MODE_SET_VALUE: value_next[c] = pop_cmd.word;
                        MODE_SET_POLY:  poly_next[c]  = pop_cmd.word;
                        default:        ;
                    endcase
                end
            end
        end
    end

    // Result register: a good read returns the channel value, all else zero.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        read_value_next = read_value_reg;
        status_next     = status_reg;
        if (exec)
        begin
            out_valid_next = 1'b1;
            status_next    = pop_cmd.status;
            if ((pop_cmd.mode == MODE_READ) && !pop_cmd.status)
            begin
                read_value_next = READ_W'(value_reg[pop_cmd.read_idx]);
            end
            else
            begin
                read_value_next = '0;
            end
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                value_reg[c] <= '0;
                poly_reg[c]  <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            value_reg     <= value_next;
            poly_reg      <= poly_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.read_value = read_value_reg;
    assign result.status     = status_reg;

`ifndef SYNTHESIS
    // A failed or non-read request never carries a value.
    assert_bad_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (read_value_reg == '0))
        else $error("bad-mask result carries a nonzero value");

    // Setting the value of channel zero takes effect on the next cycle.
    assert_set_value: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && (pop_cmd.mode == MODE_SET_VALUE) && pop_cmd.chan_mask[0])
        |=> (value_reg[0] == $past(pop_cmd.word)))
        else $error("set value did not reach channel zero");

    // Setting the polynomial leaves the running value alone.
    assert_set_poly: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && (pop_cmd.mode == MODE_SET_POLY) && pop_cmd.chan_mask[0])
        |=> ((poly_reg[0] == $past(pop_cmd.word)) && $stable(value_reg[0])))
        else $error("set polynomial misbehaved on channel zero");

    // Every executed command leaves a result waiting.
    assert_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> out_valid_reg)
        else $error("executed command produced no result");
`endif

endmodule

`default_nettype wire

// ----- hdl/multi_channel_crc_bank.sv -----
// Top level of the multi-channel CRC bank: front end, command queue and back end.
// Depends on mccb_pkg, mccb_if.sv, mccb_front, mccb_queue and mccb_back.
`timescale 1ns / 1ps
`default_nettype none

// A bank of CHANNELS independent MSB-first CRC channels, each with its own
// polynomial and running value, both zero after reset. Each request carries a
// mode, a channel mask and a data word, and produces exactly one result. While
// the result channel is ready, the block takes one request per clock and
// delivers one result per clock. An accepted request waits in the two-entry
// command queue; when the back end takes it, it runs the eight-step byte update
// of all masked channels and loads the result register. Results are held while
// the result channel stalls, and requests keep flowing into the queue until it
// holds two commands; a full queue takes a new request again in the cycle after
// a command leaves it.
module multi_channel_crc_bank (
    input  logic        clk,
    input  logic        rst_n,
    mccb_req_if.sink    request,
    mccb_rsp_if.source  result
);
    import mccb_pkg::*;

    logic  push_valid;
    logic  push_ready;
    cmd_t  push_cmd;
    logic  pop_valid;
    logic  pop_ready;
    cmd_t  pop_cmd;

    // Request decode.
    mccb_front u_front (
        .request    (request),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Command queue.
    mccb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Channel state and results.
    mccb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .result    (result)
    );

endmodule

`default_nettype wire

// ----- tb/mccb_crc_checker.sv -----
// Scoreboard for the CRC bank: mirrors every channel's value and polynomial,
// predicts one result per accepted request and compares the results in order.
// Depends on mccb_pkg for widths, the command type and the operation codes.
`timescale 1ns / 1ps

module mccb_crc_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  mccb_pkg::mode_t             req_mode,
    input  logic [mccb_pkg::MASK_W-1:0] req_mask,
    input  logic [mccb_pkg::DATA_W-1:0] req_data,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic [mccb_pkg::READ_W-1:0] rsp_read_value,
    input  logic                        rsp_status,
    output int                          fail_count,
    output int                          pending,
    output int                          checked
);
    import mccb_pkg::*;

    typedef struct packed {
        logic [READ_W-1:0] read_value;
        logic              status;
    } crc_result_t;

    // Mirror of the bank state.
    crc_t chan_value [CHANNELS];
    crc_t chan_poly  [CHANNELS];

    // Results predicted but not yet delivered, oldest first.
    crc_result_t pending_results [$];

    // Bit-serial form of the MSB-first byte update: the feedback is the top
    // bit XORed with the next data bit, which equals the shift-and-XOR of crc_byte.
    function automatic crc_t shift_in_byte(crc_t cur, crc_t poly, logic [7:0] data);
        crc_t acc;
        logic fb;
        acc = cur;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = acc[CRC_WIDTH-1] ^ data[i];
            acc = acc << 1;
            if (fb)
            begin
                acc = acc ^ poly;
            end
        end
        return acc;
    endfunction

    // Applies one request to the mirror and returns the result it must produce.
    function automatic crc_result_t apply_request(mode_t m, logic [MASK_W-1:0] mask,
                                                  logic [DATA_W-1:0] data);
        crc_result_t r;
        crc_t        word;
        r    = '0;
        word = crc_t'(data);
        case (m)
            MODE_UPDATE:
            begin
                // An empty mask simply touches nothing.
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (mask[c])
                    begin
                        chan_value[c] = shift_in_byte(chan_value[c], chan_poly[c], data[7:0]);
                    end
                end
            end
            MODE_SET_VALUE, MODE_SET_POLY:
            begin
                if (mask == '0)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (mask[c] && m == MODE_SET_VALUE)
                        begin
                            chan_value[c] = word;
                        end
                        else if (mask[c])
                        begin
                            chan_poly[c] = word;
                        end
                    end
                end
            end
            default:
            begin
                // A read needs exactly one bit set, and it must name a channel.
                r.status = 1'b1;
                if (mask != '0 && (mask & (mask - 1'b1)) == '0)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (mask == (MASK_W'(1) << c))
                        begin
                            r.read_value = READ_W'(chan_value[c]);
                            r.status     = 1'b0;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Compare delivered results first, then record the request of this edge:
    // a result can never belong to a request accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        crc_result_t want;
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                chan_value[c] = '0;
                chan_poly[c]  = '0;
            end
            pending_results.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result read_value=%h status=%0d",
                             $time, rsp_read_value, rsp_status);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    checked++;
                    if (rsp_read_value !== want.read_value)
                    begin
                        $display("%0t: read_value mismatch: expected %h, got %h",
                                 $time, want.read_value, rsp_read_value);
                        fail_count++;
                    end
                    if (rsp_status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, rsp_status);
                        fail_count++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                pending_results.push_back(apply_request(req_mode, req_mask, req_data));
            end
            pending = pending_results.size();
        end
    end

endmodule

// ----- tb/tb_multi_channel_crc_bank.sv -----
// Top of the CRC bank testbench: clock, reset, request stimulus, result stalls.
// Depends on mccb_pkg, the channel interfaces, the bank and mccb_crc_checker.
`timescale 1ns / 1ps

module tb_multi_channel_crc_bank;
    import mccb_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AT_ITEM = 200;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_CHOPPY} rx_pattern_t;

    logic clk;
    logic rst_n;

    mccb_req_if request_ch();
    mccb_rsp_if result_ch();

    int fail_count;
    int pending;
    int checked;

    int sent_count;
    int mode_count [4];
    int burst_left;
    int cycles;
    bit hold_req;
    bit hold_active;
    bit hold_done;

    multi_channel_crc_bank u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    mccb_crc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (request_ch.valid),
        .req_ready      (request_ch.ready),
        .req_mode       (request_ch.mode),
        .req_mask       (request_ch.channel_mask),
        .req_data       (request_ch.data_word),
        .rsp_valid      (result_ch.valid),
        .rsp_ready      (result_ch.ready),
        .rsp_read_value (result_ch.read_value),
        .rsp_status     (result_ch.status),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on the total run length.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
        $display("FAIL");
        $finish;
    end

    // Offers one request at a falling edge and returns at the falling edge after
    // it is taken. Bursts of random length are separated by random gaps.
    task automatic issue_request(input mode_t m, input logic [MASK_W-1:0] mask,
                                 input logic [DATA_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            if (hold_active)
            begin
                gap = 0;
            end
            if (gap > 0)
            begin
                request_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        request_ch.valid        = 1'b1;
        request_ch.mode         = m;
        request_ch.channel_mask = mask;
        request_ch.data_word    = data;
        @(posedge clk);
        while (!request_ch.ready)
        begin
            @(posedge clk);
        end
        sent_count++;
        mode_count[m]++;
        if (sent_count == HOLD_AT_ITEM)
        begin
            hold_req = 1'b1;
        end
        @(negedge clk);
    endtask

    function automatic logic [MASK_W-1:0] pick_mask();
        logic [MASK_W-1:0] mask;
        case ($urandom_range(0, 5))
            0: mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
            1: mask = '1;
            2: mask = MASK_W'($urandom) & MASK_W'($urandom);
            default: mask = MASK_W'($urandom);
        endcase
        return mask;
    endfunction

    function automatic logic [DATA_W-1:0] pick_poly();
        logic [DATA_W-1:0] poly;
        case ($urandom_range(0, 7))
            0: poly = 32'h04C1_1DB7;
            1: poly = 32'h1EDC_6F41;
            2: poly = 32'h0000_0000;
            3: poly = 32'hFFFF_FFFF;
            4: poly = 32'h8000_0000;
            5: poly = 32'h0000_0001;
            default: poly = $urandom;
        endcase
        return poly;
    endfunction

    // A typical use: program a group of channels, feed it bytes, read it back.
    task automatic run_sequence();
        logic [MASK_W-1:0] group;
        logic [MASK_W-1:0] sub;
        int                ch;
        int                n_upd;
        int                n_rd;
        group = pick_mask();
        if (group == '0)
        begin
            group = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
        end
        if ($urandom_range(0, 1) == 0)
        begin
            issue_request(MODE_SET_POLY, group, pick_poly());
        end
        if ($urandom_range(0, 3) != 0)
        begin
            issue_request(MODE_SET_VALUE, group,
                          ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
        end
        n_upd = $urandom_range(1, 8);
        for (int i = 0; i < n_upd; i++)
        begin
            sub = ($urandom_range(0, 2) == 0) ? (group & MASK_W'($urandom)) : group;
            issue_request(MODE_UPDATE, sub, $urandom);
        end
        n_rd = $urandom_range(1, 3);
        for (int i = 0; i < n_rd; i++)
        begin
            do
            begin
                ch = $urandom_range(0, MASK_W - 1);
            end
            while (!group[ch]);
            issue_request(MODE_READ, MASK_W'(1) << ch, $urandom);
        end
    endtask

    // Result side: stalls follow a pattern that changes from phase to phase,
    // with one long hold-off once the request side has gotten going.
    initial
    begin
        rx_pattern_t pattern;
        int          phase_left;
        int          tick;
        phase_left = 0;
        tick       = 0;
        pattern    = RX_STEADY;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_active     = 1'b1;
                result_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_active = 1'b0;
                hold_done   = 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    pattern    = rx_pattern_t'($urandom_range(0, 3));
                    phase_left = $urandom_range(30, 150);
                end
                phase_left--;
                tick++;
                case (pattern)
                    RX_STEADY:   result_ch.ready = 1'b1;
                    RX_RANDOM:   result_ch.ready = ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: result_ch.ready = ((tick % 7) < 4);
                    default:     result_ch.ready = $urandom_range(0, 1);
                endcase
            end
        end
    end

    // Request side: reset, directed cases, random traffic, drain and verdict.
    initial
    begin
        rst_n                   = 1'b0;
        request_ch.valid        = 1'b0;
        request_ch.mode         = MODE_UPDATE;
        request_ch.channel_mask = '0;
        request_ch.data_word    = '0;
        sent_count              = 0;
        burst_left              = 0;
        hold_req                = 1'b0;
        hold_active             = 1'b0;
        hold_done               = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            mode_count[i] = 0;
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Reads after reset: a valid one, an empty mask and a full mask.
        issue_request(MODE_READ, 16'h0001, 32'h0);
        issue_request(MODE_READ, 16'h0000, 32'h0);
        issue_request(MODE_READ, 16'hFFFF, 32'hFFFF_FFFF);
        // Sets with an empty mask are refused; an empty update is fine.
        issue_request(MODE_SET_VALUE, 16'h0000, 32'hFFFF_FFFF);
        issue_request(MODE_SET_POLY, 16'h0000, 32'h04C1_1DB7);
        issue_request(MODE_UPDATE, 16'h0000, 32'hFFFF_FFFF);
        // With a zero polynomial the value only shifts.
        issue_request(MODE_UPDATE, 16'hFFFF, 32'h0000_005A);
        issue_request(MODE_SET_VALUE, 16'hFFFF, 32'hFFFF_FFFF);
        issue_request(MODE_UPDATE, 16'h0001, 32'h0000_00A5);
        issue_request(MODE_READ, 16'h0001, 32'h0);
        // Standard polynomial on every channel, then channel 13 on its own.
        issue_request(MODE_SET_POLY, 16'hFFFF, 32'h04C1_1DB7);
        issue_request(MODE_SET_VALUE, 16'hFFFF, 32'h0000_0000);
        issue_request(MODE_UPDATE, 16'hFFFF, 32'hFFFF_FFFF);
        issue_request(MODE_UPDATE, 16'h2000, 32'h1234_5600);
        issue_request(MODE_READ, 16'h2000, 32'h0);
        issue_request(MODE_READ, 16'h8000, 32'h0);
        // Extreme polynomial on the top channel.
        issue_request(MODE_SET_POLY, 16'h8000, 32'hFFFF_FFFF);
        issue_request(MODE_UPDATE, 16'h8000, 32'h0000_00FF);
        issue_request(MODE_READ, 16'h8000, 32'hFFFF_FFFF);
        // Top bit set with a zero byte forces the feedback path.
        issue_request(MODE_SET_VALUE, 16'h0010, 32'h8000_0000);
        issue_request(MODE_UPDATE, 16'h0010, 32'h0000_0000);
        issue_request(MODE_READ, 16'h0010, 32'h0);
        issue_request(MODE_READ, 16'h0003, 32'h0);

        // Mostly well-formed sequences, with some fully random requests mixed in.
        while (sent_count < RANDOM_ITEMS + 23)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                issue_request(mode_t'($urandom_range(0, 3)),
                              ($urandom_range(0, 7) == 0) ? '0 : pick_mask(), $urandom);
            end
            else
            begin
                run_sequence();
            end
        end
        request_ch.valid = 1'b0;

        // Drain, then allow for the pipeline latency.
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("Covered %0d requests: %0d update, %0d set value, %0d set polynomial, %0d read",
                 sent_count, mode_count[MODE_UPDATE], mode_count[MODE_SET_VALUE],
                 mode_count[MODE_SET_POLY], mode_count[MODE_READ]);
        $display("Checked %0d results, with one %0d-cycle result hold-off; %0d mismatches",
                 checked, HOLD_CYCLES, fail_count);
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
